// ===== hw/rtl/rpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants of the region perceived brightness meter.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam logic [15:0] WEIGHT_RED   = 16'd19595;
  localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;
  localparam logic [7:0]  FULL_SCALE   = 8'd255;

  localparam int SUM_W   = 40;
  localparam int TALLY_W = 25;
  localparam int WSUM_W  = 32;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_REGION_LEFT   = 3'd1;
  localparam logic [2:0] REG_REGION_TOP    = 3'd2;
  localparam logic [2:0] REG_REGION_WIDTH  = 3'd3;
  localparam logic [2:0] REG_REGION_HEIGHT = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new pixel, start the root
    logic root;     // one root iteration
    logic acc;      // accumulate and advance position
    logic div_go;   // start the frame division
    logic div_step; // one division iteration
    logic finish;   // latch result, clear frame state
  } rpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_done;
    logic div_done;
    logic last;
  } rpb_sts_t;

endpackage

// ===== hw/rtl/rpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpb_ctrl
// Sequencer that steps one pixel through root, accumulation and, on the
// frame's last pixel, the average division.
// ----------------------------------------------------------------------------
module rpb_ctrl
  import rpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rpb_sts_t sts,
  output rpb_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // A new pixel is taken once the previous result has left or leaves now.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (sts.root_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_DIV;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/rpb_datapath.sv =====
// ----------------------------------------------------------------------------
// rpb_datapath
// Weighted square sum, bit-serial square root, region accumulators and a
// restoring divider for the frame average.
// ----------------------------------------------------------------------------
module rpb_datapath
  import rpb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int DIM_W         = $clog2(MAX_DIMENSION + 1),
  parameter int POS_W         = $clog2(MAX_DIMENSION)
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  rpb_cmd_t         cmd,
  output rpb_sts_t         sts,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic             in_frame_end,
  input  logic [DIM_W-1:0] image_width,
  input  logic [11:0]      region_left,
  input  logic [11:0]      region_top,
  input  logic [12:0]      region_width,
  input  logic [12:0]      region_height,
  output logic [15:0]      out_pixel_level,
  output logic [15:0]      out_region_average,
  output logic             out_average_valid,
  output logic             out_region_empty
);

  localparam int QW   = SUM_W + 8;        // dividend width
  localparam int DVW  = TALLY_W + 8;      // divisor width
  localparam int CNTW = $clog2(QW + 1);
  localparam logic [CNTW-1:0] QW_C = CNTW'(QW);
  localparam logic [POS_W-1:0] ROW_MAX = POS_W'(MAX_DIMENSION - 1);

  // Pixel capture: squares are registered before the weights are applied.
  logic [15:0]       rsq_r, gsq_r, bsq_r;
  logic              last_r;
  logic              wsum_ok_r;
  logic [WSUM_W-1:0] rem_r;
  logic [15:0]       res_r;
  logic [4:0]        rcnt_r;
  logic [15:0]       level_r;

  // Root iteration: two bits of the radicand per cycle, one result bit.
  logic [WSUM_W-1:0] wsum;
  logic [WSUM_W-1:0] wsum_r;
  logic [WSUM_W+1:0] trial;
  logic [WSUM_W+1:0] rem_sh;
  logic [15:0]       res_root;

  assign wsum = 32'(WEIGHT_RED) * 32'(rsq_r) + 32'(WEIGHT_GREEN) * 32'(gsq_r)
              + 32'(WEIGHT_BLUE) * 32'(bsq_r);
  assign rem_sh   = {rem_r, wsum_r[WSUM_W-1 -: 2]};
  assign trial    = {16'd0, res_r, 2'b01};
  assign res_root = res_r;

  // Position and accumulators.
  logic [POS_W-1:0]   col_r, row_r;
  logic [SUM_W-1:0]   sum_r;
  logic [TALLY_W-1:0] tally_r;
  logic [DIM_W-1:0]   eff_w;
  logic               in_region;
  logic [SUM_W:0]     sum_add;
  logic [13:0]        col_hi, row_hi;

  always_comb begin
    eff_w = image_width;
    if (image_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(image_width) > MAX_DIMENSION) begin
      eff_w = DIM_W'(MAX_DIMENSION);
    end
  end

  assign col_hi    = 14'(region_left) + 14'(region_width);
  assign row_hi    = 14'(region_top) + 14'(region_height);
  assign in_region = (32'(col_r) >= 32'(region_left)) && (32'(col_r) < 32'(col_hi))
                  && (32'(row_r) >= 32'(region_top)) && (32'(row_r) < 32'(row_hi))
                  && (32'(col_r) < 32'(eff_w));
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(level_r);

  // Divider: q = floor(sum * 256 / (255 * tally)), restoring, one bit a cycle.
  logic [QW-1:0]   dvd_r;
  logic [DVW-1:0]  dvs_r;
  logic [DVW:0]    prem_r;
  logic [CNTW-1:0] dcnt_r;
  logic [DVW:0]    prem_sh;
  logic [DVW+1:0]  prem_sub;
  logic            empty_r;

  assign prem_sh  = {prem_r[DVW-1:0], dvd_r[QW-1]};
  assign prem_sub = {1'b0, prem_sh} - {2'b00, dvs_r};

  assign sts.root_done = (rcnt_r == 5'd15);
  assign sts.div_done  = (dcnt_r == QW_C - CNTW'(1));
  assign sts.last      = last_r;

  logic [15:0] avg_r;
  logic        avgv_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsq_r     <= in_red * in_red;
      gsq_r     <= in_green * in_green;
      bsq_r     <= in_blue * in_blue;
      last_r    <= in_frame_end;
      wsum_ok_r <= 1'b0;
      rem_r     <= '0;
      res_r     <= '0;
      rcnt_r    <= '0;
    end
    if (cmd.root) begin
      if (!wsum_ok_r) begin
        wsum_r    <= wsum;
        wsum_ok_r <= 1'b1;
      end else begin
        wsum_r <= {wsum_r[WSUM_W-3:0], 2'b00};
        rcnt_r <= rcnt_r + 5'd1;
        if (rem_sh >= trial) begin
          rem_r <= WSUM_W'(rem_sh - trial);
          res_r <= {res_root[14:0], 1'b1};
          if (rcnt_r == 5'd15) level_r <= {res_root[14:0], 1'b1};
        end else begin
          rem_r <= WSUM_W'(rem_sh);
          res_r <= {res_root[14:0], 1'b0};
          if (rcnt_r == 5'd15) level_r <= {res_root[14:0], 1'b0};
        end
      end
    end
    if (cmd.div_go) begin
      dvd_r  <= {(in_region && sum_add[SUM_W]) ? {SUM_W{1'b1}} :
                 (in_region ? sum_add[SUM_W-1:0] : sum_r), 8'd0};
      dvs_r  <= DVW'(FULL_SCALE) * DVW'((in_region && tally_r != '1) ?
                 tally_r + TALLY_W'(1) : tally_r);
      empty_r <= !in_region && (tally_r == '0);
      prem_r <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + CNTW'(1);
      if (!prem_sub[DVW+1]) begin
        prem_r <= prem_sub[DVW:0];
        dvd_r  <= {dvd_r[QW-2:0], 1'b1};
      end else begin
        prem_r <= prem_sh;
        dvd_r  <= {dvd_r[QW-2:0], 1'b0};
      end
    end
  end

  // Frame state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_r   <= '0;
      tally_r <= '0;
      avgv_r  <= 1'b0;
      avg_r   <= '0;
    end else begin
      if (cmd.acc) begin
        avgv_r <= 1'b0;
        avg_r  <= '0;
        if (in_region) begin
          sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          if (tally_r != '1) tally_r <= tally_r + TALLY_W'(1);
        end
        if (!last_r) begin
          if (32'(col_r) + 1 >= 32'(eff_w)) begin
            col_r <= '0;
            if (row_r != ROW_MAX) row_r <= row_r + POS_W'(1);
          end else begin
            col_r <= col_r + POS_W'(1);
          end
        end
      end
      if (cmd.finish) begin
        avgv_r  <= 1'b1;
        avg_r   <= empty_r ? 16'd0 :
                   ((dvd_r[QW-1:16] != '0) ? 16'hFFFF : dvd_r[15:0]);
        sum_r   <= '0;
        tally_r <= '0;
        col_r   <= '0;
        row_r   <= '0;
      end
    end
  end

  assign out_pixel_level    = level_r;
  assign out_region_average = avg_r;
  assign out_average_valid  = avgv_r;
  assign out_region_empty   = avgv_r && empty_r;

endmodule

// ===== hw/rtl/region_perceived_brightness.sv =====
// ----------------------------------------------------------------------------
// region_perceived_brightness
// Per-pixel HSP brightness with a rectangular region average per frame.
// ----------------------------------------------------------------------------
// Sequence: an accepted pixel is captured, passes the 16-step square root
//   and is accumulated; frame-end words then pass the restoring average divider.
// A new pixel is taken only once the previous one is through and its word has left.
// Reset (synchronous, rst_n low): registers return to full-frame defaults,
//   position and accumulators clear, no word is pending.
module region_perceived_brightness
  import rpb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_level,
  output logic [15:0] out_region_average,
  output logic        out_average_valid,
  output logic        out_region_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

  rpb_cmd_t cmd;
  rpb_sts_t sts;

  // Configuration registers, always writable; users must write only while idle (not enforced).
  logic [12:0] image_width_r;
  logic [11:0] region_left_r, region_top_r;
  logic [12:0] region_width_r, region_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 13'd4096;
      region_left_r   <= '0;
      region_top_r    <= '0;
      region_width_r  <= 13'd4096;
      region_height_r <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
        REG_REGION_LEFT:   region_left_r   <= cfg_data[11:0];
        REG_REGION_TOP:    region_top_r    <= cfg_data[11:0];
        REG_REGION_WIDTH:  region_width_r  <= cfg_data;
        REG_REGION_HEIGHT: region_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Widths beyond the parameter's range clamp to the largest dimension.
  logic [DIM_W-1:0] image_width_eff;
  assign image_width_eff = (32'(image_width_r) > MAX_DIMENSION) ?
                           DIM_W'(MAX_DIMENSION) : DIM_W'(image_width_r);

  rpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpb_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_frame_end       (in_frame_end),
    .image_width        (image_width_eff),
    .region_left        (region_left_r),
    .region_top         (region_top_r),
    .region_width       (region_width_r),
    .region_height      (region_height_r),
    .out_pixel_level    (out_pixel_level),
    .out_region_average (out_region_average),
    .out_average_valid  (out_average_valid),
    .out_region_empty   (out_region_empty)
  );

endmodule

// ===== verif/rpb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpb_checker
// Watches the pixel, result and register channels of the brightness meter,
// predicts every result word from its own copy of the frame state and
// compares each one, field by field, in order.
// ----------------------------------------------------------------------------
module rpb_checker
  import rpb_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_pixel_level,
  input  logic [15:0] out_region_average,
  input  logic        out_average_valid,
  input  logic        out_region_empty,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] average;
    logic        avg_valid;
    logic        empty;
  } brightness_word_t;

  localparam logic [SUM_W-1:0]   SUM_FULL   = '1;
  localparam logic [TALLY_W-1:0] TALLY_FULL = '1;

  brightness_word_t expected_words[$];

  logic [12:0] img_width, reg_width, reg_height;
  logic [11:0] reg_left, reg_top;
  logic [11:0] col_pos, row_pos;
  logic [SUM_W-1:0]   level_sum;
  logic [TALLY_W-1:0] level_tally;

  // Floor square root by setting result bits from the top down.
  function automatic logic [15:0] floor_sqrt(input logic [31:0] w);
    logic [63:0] trial;
    logic [15:0] root;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = {48'd0, root | (16'd1 << i)};
      if (trial * trial <= {32'd0, w}) root = trial[15:0];
    end
    return root;
  endfunction

  // Works out the word for one pixel and advances the frame state.
  function automatic brightness_word_t predict_pixel(input logic [7:0] r, g, b,
                                                     input logic last);
    brightness_word_t wd;
    logic [31:0] wsum;
    int eff_w;
    logic hit;
    logic [63:0] quo;
    eff_w = (img_width == 0) ? 1 : (img_width > MAX_DIMENSION) ? MAX_DIMENSION
                                                                 : int'(img_width);
    wsum = WEIGHT_RED * r * r + WEIGHT_GREEN * g * g + WEIGHT_BLUE * b * b;
    wd = '0;
    wd.level = floor_sqrt(wsum);
    hit = int'(col_pos) >= int'(reg_left) && int'(col_pos) < int'(reg_left) + int'(reg_width)
       && int'(row_pos) >= int'(reg_top) && int'(row_pos) < int'(reg_top) + int'(reg_height)
       && int'(col_pos) < eff_w;
    if (hit) begin
      level_sum = (level_sum > SUM_FULL - wd.level) ? SUM_FULL : level_sum + wd.level;
      if (level_tally != TALLY_FULL) level_tally++;
    end
    if (last) begin
      wd.avg_valid = 1'b1;
      if (level_tally == 0) begin
        wd.empty = 1'b1;
      end else begin
        quo = ({24'd0, level_sum} * 64'd256) / (64'd255 * {39'd0, level_tally});
        wd.average = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
      end
      level_sum = '0;
      level_tally = '0;
      col_pos = '0;
      row_pos = '0;
    end else if (int'(col_pos) + 1 >= eff_w) begin
      col_pos = '0;
      if (row_pos < MAX_DIMENSION - 1) row_pos++;
    end else begin
      col_pos++;
    end
    return wd;
  endfunction

  always @(posedge clk) begin
    brightness_word_t want, got;
    if (!rst_n) begin
      img_width = 13'd4096;
      reg_left = '0;
      reg_top = '0;
      reg_width = 13'd4096;
      reg_height = 13'd4096;
      col_pos = '0;
      row_pos = '0;
      level_sum = '0;
      level_tally = '0;
      expected_words.delete();
      failures <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   img_width = cfg_data;
          REG_REGION_LEFT:   reg_left = cfg_data[11:0];
          REG_REGION_TOP:    reg_top = cfg_data[11:0];
          REG_REGION_WIDTH:  reg_width = cfg_data;
          REG_REGION_HEIGHT: reg_height = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_pixel(in_red, in_green, in_blue, in_frame_end));
      if (out_valid && out_ready) begin
        got = '{out_pixel_level, out_region_average, out_average_valid, out_region_empty};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word level=%0d average=%0d valid=%0b empty=%0b",
                   $time, got.level, got.average, got.avg_valid, got.empty);
          failures <= failures + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: word mismatch expected level=%0d average=%0d valid=%0b empty=%0b",
                     $time, want.level, want.average, want.avg_valid, want.empty);
            $display("%0t:                 actual level=%0d average=%0d valid=%0b empty=%0b",
                     $time, got.level, got.average, got.avg_valid, got.empty);
            failures <= failures + 1;
          end
        end
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the region perceived brightness meter: directed
// corner pixels and regions, then random frames under many region settings
// and three idling patterns, all checked word by word by rpb_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import rpb_pkg::*;

  // An index outside the register map; a write there must change nothing.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PIXELS = 1030;

  logic clk, rst_n;
  logic in_valid, in_ready, in_frame_end;
  logic [7:0] in_red, in_green, in_blue;
  logic out_valid, out_ready, out_average_valid, out_region_empty;
  logic [15:0] out_pixel_level, out_region_average;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [12:0] cfg_data;

  int failures, outstanding;
  int send_idle_pct, recv_idle_pct;
  int pixels_sent, frames_sent, cfg_writes, idle_cycles;

  region_perceived_brightness u_top (.*);
  rpb_checker u_checker (.*);

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // The receiver stalls at random according to the current idling pattern.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The watchdog counts cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles at %0t", STALL_LIMIT, $time);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sends one pixel. Called at a rising edge and returns at the edge where
  // the pixel is accepted, so valid is only lowered when a gap follows.
  task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_frame_end <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  // Waits until every expected word is back and the block has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is drained. Valid drops for
  // one cycle after each write.
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_region(input logic [12:0] img_w, left, top, reg_w, reg_h);
    write_reg(REG_IMAGE_WIDTH, img_w);
    write_reg(REG_REGION_LEFT, left);
    write_reg(REG_REGION_TOP, top);
    write_reg(REG_REGION_WIDTH, reg_w);
    write_reg(REG_REGION_HEIGHT, reg_h);
  endtask

  function automatic logic [7:0] pick_component();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Small sizes mostly, with the extremes and fully random codes now and then.
  function automatic logic [12:0] pick_size();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom);
      default: return 13'($urandom_range(1, 7));
    endcase
  endfunction

  function automatic logic [12:0] pick_offset();
    case ($urandom_range(7))
      0: return 13'd4095;
      1: return 13'($urandom);
      default: return 13'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    int frame_len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 7;
    recv_idle_pct = 73;
    pixels_sent = 0;
    frames_sent = 0;
    cfg_writes = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset region: black, white and each primary,
    // then a single white pixel whose average saturates at full scale, then a single black pixel.
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    wait_drained();
    write_reg(REG_UNMAPPED, 13'h1FFF);

    // Empty region: zero width gives a zero average and the empty flag.
    set_region(13'd4, 13'd0, 13'd0, 13'd0, 13'd4096);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b1);
    wait_drained();

    // Zero image width acts as one; the region covers only row one.
    set_region(13'd0, 13'd0, 13'd1, 13'd1, 13'd1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    wait_drained();

    // Region wider than the row: columns beyond the width do not count, and
    // an oversized width code acts as the largest width.
    set_region(13'd2, 13'd1, 13'd0, 13'd4096, 13'd4096);
    send_pixel(8'd9, 8'd9, 8'd9, 1'b0);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    wait_drained();
    set_region(13'h1FFF, 13'h1FFF, 13'd0, 13'h1FFF, 13'h1FFF);
    send_pixel(8'd77, 8'd1, 8'd254, 1'b0);
    send_pixel(8'd3, 8'd250, 8'd128, 1'b1);
    wait_drained();

    // Random frames; the region may change between frames, the idling pattern
    // switches after each third of the pixels.
    while (pixels_sent < RANDOM_PIXELS) begin
      if (pixels_sent >= 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (pixels_sent >= RANDOM_PIXELS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 7;
      end
      if ($urandom_range(2) == 0) begin
        wait_drained();
        set_region(pick_size(), pick_offset(), pick_offset(), pick_size(), pick_size());
      end
      frame_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 25);
      for (int i = 0; i < frame_len; i++)
        send_pixel(pick_component(), pick_component(), pick_component(),
                   i == frame_len - 1);
    end

    wait_drained();
    $display("Covered %0d pixels in %0d frames with %0d register writes,", pixels_sent,
             frames_sent, cfg_writes);
    $display("across empty, clipped, saturating and random regions and three idle patterns.");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
